// ===== src/rpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rpd_pkg
// Types and constants shared by the run-length packet decoder modules.
// ----------------------------------------------------------------------------
package rpd_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BYTES_PER_PIXEL = 1'b0,
		CFG_IMAGE_PIXELS    = 1'b1
	} cfg_idx_t;

	// header byte fields
	localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;
	localparam logic [7:0] HDR_RUN_FLAG   = 8'h80;

	// register reset values
	localparam logic [2:0]  BPP_RESET = 3'd1;
	localparam logic [31:0] IMG_RESET = 32'd1;

	// decoder phase
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_RAW    = 2'd1,
		PH_RUN    = 2'd2,
		PH_ERROR  = 2'd3
	} phase_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERRUN   = 2'd1,
		ST_EARLY_END = 2'd2
	} status_t;

	// kind of a queued stream item
	typedef enum logic {
		ITEM_BYTE = 1'b0,
		ITEM_EOS  = 1'b1
	} item_kind_t;

	typedef struct packed {
		item_kind_t kind;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [31:0] pixel;
		logic [7:0]  rep;
		logic        done;
		status_t     status;
	} result_t;

	// configuration write request
	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [31:0]          data;
	} cfg_wr_t;

endpackage

// ===== src/rpd_fifo.sv =====
// ----------------------------------------------------------------------------
// rpd_fifo
// Small register queue with push/pop handshake, used between stages.
// ----------------------------------------------------------------------------
module rpd_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_ok, rd_ok;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign wr_ok = wr_en && !full;
	assign rd_ok = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_ok, rd_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/rpd_front.sv =====
// ----------------------------------------------------------------------------
// rpd_front
// Accepts stream requests, tags each as data byte or end of stream and
// queues it for the decoder.
// ----------------------------------------------------------------------------
module rpd_front import rpd_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] stream_byte,
	input  logic       end_of_stream,
	input  logic       q_rd_en,
	output item_t      q_item,
	output logic       q_empty
);

	item_t                   item_in;
	logic [$bits(item_t)-1:0] q_data;

	// classify the incoming request
	always_comb begin
		item_in.kind = end_of_stream ? ITEM_EOS : ITEM_BYTE;
		item_in.data = end_of_stream ? 8'd0 : stream_byte;
	end

	// queue towards the decoder
	rpd_fifo #(
		.WIDTH($bits(item_t)),
		.DEPTH(DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(item_in),
		.full   (full),
		.rd_en  (q_rd_en),
		.rd_data(q_data),
		.empty  (q_empty)
	);

	assign q_item = item_t'(q_data);

endmodule

// ===== src/rpd_back.sv =====
// ----------------------------------------------------------------------------
// rpd_back
// Packet decoder: header parsing, pixel assembly, image accounting and
// error flagging, with a result queue towards the consumer.
// ----------------------------------------------------------------------------
module rpd_back import rpd_pkg::*; #(
	parameter int unsigned OUT_DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg_wr,
	input  item_t   q_item,
	input  logic    q_empty,
	output logic    q_rd_en,
	output result_t res,
	output logic    res_empty,
	input  logic    res_pop
);

	// configuration
	logic [2:0]  bpp_q;
	logic [31:0] img_q;

	// decoder state
	phase_t      phase_q, phase_d;
	logic [23:0] partial_q, partial_d;
	logic [1:0]  bpos_q, bpos_d;
	logic [7:0]  left_q, left_d;
	logic [31:0] pix_done_q, pix_done_d;

	logic        out_full;
	logic        take;
	logic        emit;
	result_t     res_d;
	logic [$bits(result_t)-1:0] res_data;

	logic [2:0]  bpp_eff;
	logic [7:0]  count;
	logic [32:0] sum_hdr, sum_pix;
	logic [31:0] shifted, pix;
	logic [7:0]  rep;
	logic        last_byte, img_full;

	assign q_rd_en = !out_full;
	assign take    = !q_empty && !out_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= BPP_RESET;
			img_q <= IMG_RESET;
		end else if (cfg_wr.valid) begin
			case (cfg_idx_t'(cfg_wr.index))
				CFG_BYTES_PER_PIXEL: bpp_q <= cfg_wr.data[2:0];
				CFG_IMAGE_PIXELS:    img_q <= cfg_wr.data;
				default:             img_q <= img_q;
			endcase
		end
	end

	// pixel size clamped to one..four bytes
	always_comb begin
		if (bpp_q == 3'd0) begin
			bpp_eff = 3'd1;
		end else if (bpp_q > 3'd4) begin
			bpp_eff = 3'd4;
		end else begin
			bpp_eff = bpp_q;
		end
	end

	// byte placed at its lane within the pixel
	always_comb begin
		case (bpos_q)
			2'd0:    shifted = {24'd0, q_item.data};
			2'd1:    shifted = {16'd0, q_item.data, 8'd0};
			2'd2:    shifted = {8'd0, q_item.data, 16'd0};
			default: shifted = {q_item.data, 24'd0};
		endcase
	end

	// header and pixel arithmetic
	assign count     = (q_item.data & HDR_COUNT_MASK) + 8'd1;
	assign sum_hdr   = {1'b0, pix_done_q} + {25'd0, count};
	assign last_byte = ({1'b0, bpos_q} + 3'd1) >= bpp_eff;
	assign pix       = {8'd0, partial_q} | shifted;
	assign rep       = (phase_q == PH_RAW) ? 8'd1 : left_q;
	assign sum_pix   = {1'b0, pix_done_q} + {25'd0, rep};
	assign img_full  = sum_pix >= {1'b0, img_q};

	// next state and result
	always_comb begin
		phase_d    = phase_q;
		partial_d  = partial_q;
		bpos_d     = bpos_q;
		left_d     = left_q;
		pix_done_d = pix_done_q;
		emit       = 1'b0;
		res_d      = '{pixel: 32'd0, rep: 8'd0, done: 1'b0, status: ST_OK};
		if (take) begin
			if (q_item.kind == ITEM_EOS) begin
				// end of stream: flag an image left part-way
				phase_d    = PH_HEADER;
				partial_d  = '0;
				bpos_d     = '0;
				left_d     = '0;
				pix_done_d = '0;
				if (phase_q == PH_RAW || phase_q == PH_RUN ||
				    (phase_q == PH_HEADER && pix_done_q != 32'd0)) begin
					emit         = 1'b1;
					res_d.status = ST_EARLY_END;
				end
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						partial_d = '0;
						bpos_d    = '0;
						if (sum_hdr > {1'b0, img_q}) begin
							phase_d      = PH_ERROR;
							left_d       = '0;
							emit         = 1'b1;
							res_d.status = ST_OVERRUN;
						end else begin
							left_d  = count;
							phase_d = ((q_item.data & HDR_RUN_FLAG) != 8'd0) ? PH_RUN : PH_RAW;
						end
					end
					PH_RAW, PH_RUN: begin
						if (!last_byte) begin
							partial_d = pix[23:0];
							bpos_d    = bpos_q + 2'd1;
						end else begin
							partial_d   = '0;
							bpos_d      = '0;
							emit        = 1'b1;
							res_d.pixel = pix;
							res_d.rep   = rep;
							res_d.done  = img_full;
							if (img_full) begin
								phase_d    = PH_HEADER;
								left_d     = '0;
								pix_done_d = '0;
							end else begin
								pix_done_d = sum_pix[31:0];
								left_d     = left_q - rep;
								if (left_q == rep) begin
									phase_d = PH_HEADER;
								end
							end
						end
					end
					PH_ERROR: begin
						phase_d = PH_ERROR;
					end
					default: begin
						phase_d = PH_HEADER;
					end
				endcase
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			partial_q  <= '0;
			bpos_q     <= '0;
			left_q     <= '0;
			pix_done_q <= '0;
		end else begin
			phase_q    <= phase_d;
			partial_q  <= partial_d;
			bpos_q     <= bpos_d;
			left_q     <= left_d;
			pix_done_q <= pix_done_d;
		end
	end

	// result queue towards the consumer
	rpd_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(OUT_DEPTH)
	) u_results (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (emit),
		.wr_data(res_d),
		.full   (out_full),
		.rd_en  (res_pop),
		.rd_data(res_data),
		.empty  (res_empty)
	);

	assign res = result_t'(res_data);

endmodule

// ===== src/rle_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// rle_packet_decoder
// Run-length packet stream decoder: one byte per request, one result per
// finished pixel or error.
// ----------------------------------------------------------------------------
// Takes one stream byte (or an end-of-stream marker) per cycle and keeps
// taking one per cycle as long as results are popped; each request passes
// through the decoder's state update, which sets the rate.
// A request passes an input queue of QUEUE_DEPTH entries and then the decoder:
// the request is registered in the input queue, and its result, if any, is
// written into the result queue when the decoder takes the request.
// Results wait in a queue of OUT_DEPTH entries; full rises only when both
// queues have filled behind a stalled consumer. Pixels are reported once
// with their repeat count; runs are not expanded.
// Configuration writes are always ready and should be made while idle.
module rle_packet_decoder import rpd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4,
	parameter int unsigned OUT_DEPTH   = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// stream requests
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           stream_byte,
	input  logic                 end_of_stream,
	// results
	output logic                 empty,
	input  logic                 pop,
	output logic [31:0]          pixel_value,
	output logic [7:0]           repeat_count,
	output logic                 image_done,
	output logic [1:0]           status,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	item_t   q_item;
	logic    q_empty, q_rd_en;
	result_t res;
	cfg_wr_t cfg_wr;

	// configuration channel
	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	// front: accept and classify
	rpd_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.stream_byte  (stream_byte),
		.end_of_stream(end_of_stream),
		.q_rd_en      (q_rd_en),
		.q_item       (q_item),
		.q_empty      (q_empty)
	);

	// back: decode and queue results
	rpd_back #(
		.OUT_DEPTH(OUT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.q_item   (q_item),
		.q_empty  (q_empty),
		.q_rd_en  (q_rd_en),
		.res      (res),
		.res_empty(empty),
		.res_pop  (pop)
	);

	// result fields
	assign pixel_value  = res.pixel;
	assign repeat_count = res.rep;
	assign image_done   = res.done;
	assign status       = res.status;

endmodule

// ===== tb/rle_packet_decoder_checker.sv =====
// ----------------------------------------------------------------------------
// rle_packet_decoder_checker
// Watches the stream, result and register channels of the run-length packet
// decoder. It decodes every accepted request itself, queues the expected
// pixel and error results, and compares each popped result field by field
// with the oldest one waiting.
// ----------------------------------------------------------------------------
module rle_packet_decoder_checker import rpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  logic [7:0]           stream_byte,
	input  logic                 end_of_stream,
	input  logic                 empty,
	input  logic                 pop,
	input  logic [31:0]          pixel_value,
	input  logic [7:0]           repeat_count,
	input  logic                 image_done,
	input  logic [1:0]           status,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output int                   mismatches,
	output int                   owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_MAX = 10;

	// register copies
	logic [2:0]  bpp_reg;
	logic [31:0] img_reg;

	// decoder state
	phase_t      ph;
	logic [23:0] part_px;
	logic [1:0]  byte_pos;
	logic [7:0]  px_left;
	logic [31:0] px_done;

	// pixels and errors still to be popped
	result_t     pixel_q[$];

	// out-of-range pixel sizes fold onto 1 and 4
	function automatic int eff_bytes(logic [2:0] bpp);
		if (bpp == 3'd0) return 1;
		if (bpp > 3'd4) return 4;
		return int'(bpp);
	endfunction

	function automatic result_t make_result(logic [31:0] pix, logic [7:0] rep,
			logic done, status_t st);
		result_t r;
		r.pixel  = pix;
		r.rep    = rep;
		r.done   = done;
		r.status = st;
		return r;
	endfunction

	task automatic clear_image();
		ph       = PH_HEADER;
		part_px  = '0;
		byte_pos = '0;
		px_left  = '0;
		px_done  = '0;
	endtask

	// one stream request through the decoder
	task automatic decode_byte(logic [7:0] b, logic eos);
		logic        open_img;
		logic [7:0]  cnt;
		logic [32:0] total;
		logic [31:0] pix;
		logic [7:0]  rep;
		logic        fin;
		// end of stream: early end if anything of the image has come
		if (eos) begin
			open_img = (ph == PH_RAW) || (ph == PH_RUN) ||
				(ph == PH_HEADER && px_done != 32'd0);
			clear_image();
			if (open_img)
				pixel_q.push_back(make_result('0, '0, 1'b0, ST_EARLY_END));
			return;
		end
		if (ph == PH_ERROR)
			return;
		// header: open a packet unless it passes the image size
		if (ph == PH_HEADER) begin
			cnt = (b & HDR_COUNT_MASK) + 8'd1;
			if ({1'b0, px_done} + 33'(cnt) > {1'b0, img_reg}) begin
				ph       = PH_ERROR;
				part_px  = '0;
				byte_pos = '0;
				px_left  = '0;
				pixel_q.push_back(make_result('0, '0, 1'b0, ST_OVERRUN));
				return;
			end
			px_left  = cnt;
			part_px  = '0;
			byte_pos = '0;
			ph       = ((b & HDR_RUN_FLAG) != 8'd0) ? PH_RUN : PH_RAW;
			return;
		end
		// pixel byte, lowest byte first
		if (int'(byte_pos) + 1 < eff_bytes(bpp_reg)) begin
			part_px  = part_px | 24'(32'(b) << (8 * byte_pos));
			byte_pos = byte_pos + 2'd1;
			return;
		end
		pix   = {8'h00, part_px} | (32'(b) << (8 * byte_pos));
		rep   = (ph == PH_RAW) ? 8'd1 : px_left;
		total = {1'b0, px_done} + 33'(rep);
		fin   = total >= {1'b0, img_reg};
		part_px  = '0;
		byte_pos = '0;
		if (fin) begin
			clear_image();
		end else begin
			px_done = total[31:0];
			px_left = px_left - rep;
			if (px_left == 8'd0)
				ph = PH_HEADER;
		end
		pixel_q.push_back(make_result(pix, rep, fin, ST_OK));
	endtask

	// popped result against the oldest one waiting
	task automatic check_result(result_t got);
		result_t want;
		if (pixel_q.size() == 0) begin
			if (mismatches < REPORT_MAX)
				$display("unexpected result: pixel %h rep %0d done %0b status %0d",
					got.pixel, got.rep, got.done, got.status);
			mismatches++;
			return;
		end
		want = pixel_q.pop_front();
		if (got.pixel !== want.pixel || got.rep !== want.rep ||
				got.done !== want.done || got.status !== want.status) begin
			if (mismatches < REPORT_MAX)
				$display("result mismatch: expected pixel %h rep %0d done %0b status %0d,%s",
					want.pixel, want.rep, want.done, want.status,
					$sformatf(" got pixel %h rep %0d done %0b status %0d",
					got.pixel, got.rep, got.done, got.status));
			mismatches++;
		end
	endtask

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_reg = BPP_RESET;
			img_reg = IMG_RESET;
			clear_image();
			pixel_q.delete();
			mismatches = 0;
			owed = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BYTES_PER_PIXEL: bpp_reg = cfg_data[2:0];
					CFG_IMAGE_PIXELS:    img_reg = cfg_data;
					default: ;
				endcase
			end
			if (pop && !empty)
				check_result(make_result(pixel_value, repeat_count, image_done,
					status_t'(status)));
			if (push && !full)
				decode_byte(stream_byte, end_of_stream);
			owed = pixel_q.size();
		end
	end

endmodule

// ===== tb/rle_packet_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// rle_packet_decoder_tb
// Stimulus for the run-length packet decoder: a directed pass over headers,
// runs, overruns, early ends and register changes inside an image, then
// random images, cut streams and noise under varying pixel and image sizes,
// with random stalls on both queue sides. The checker beside the block does
// all prediction and comparison.
// ----------------------------------------------------------------------------
module rle_packet_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rpd_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int ITEM_TARGET   = 1750;
	localparam int SETTLE_CYCLES = 16;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 push          = 1'b0;
	logic [7:0]           stream_byte   = 8'h00;
	logic                 end_of_stream = 1'b0;
	logic                 pop           = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [31:0]          cfg_data      = 32'd0;
	logic                 full;
	logic                 empty;
	logic [31:0]          pixel_value;
	logic [7:0]           repeat_count;
	logic                 image_done;
	logic [1:0]           status;
	logic                 cfg_ready;

	int          mismatches;
	int          owed;
	bit          calm   = 1'b0;
	int          sent   = 0;
	int unsigned cycles = 0;

	rle_packet_decoder DUT (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .stream_byte(stream_byte), .end_of_stream(end_of_stream),
		.empty(empty), .pop(pop), .pixel_value(pixel_value), .repeat_count(repeat_count),
		.image_done(image_done), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rle_packet_decoder_checker result_check (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .stream_byte(stream_byte), .end_of_stream(end_of_stream),
		.empty(empty), .pop(pop), .pixel_value(pixel_value), .repeat_count(repeat_count),
		.image_done(image_done), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .mismatches(mismatches), .owed(owed)
	);

	// clock
	always #4 clk = ~clk;

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int eff_bytes(logic [2:0] bpp);
		if (bpp == 3'd0) return 1;
		if (bpp > 3'd4) return 4;
		return int'(bpp);
	endfunction

	// random stream byte
	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// one stream request, then an optional gap
	task automatic send(logic [7:0] b, logic eos);
		int gap;
		@(negedge clk);
		push          <= 1'b1;
		stream_byte   <= b;
		end_of_stream <= eos;
		forever begin
			@(posedge clk);
			if (!full) break;
		end
		sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// hold the stream until every result is out and the decoder has drained
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (owed != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(logic [2:0] bpp, logic [31:0] img);
		logic [31:0] bpp_word;
		// unused upper bits of the pixel size word get junk now and then
		bpp_word = {($urandom_range(0, 3) == 0) ? 29'($urandom) : 29'd0, bpp};
		settle();
		write_reg(CFG_BYTES_PER_PIXEL, bpp_word);
		write_reg(CFG_IMAGE_PIXELS, img);
	endtask

	task automatic send_pixel(int nb);
		repeat (nb) send(rand_byte(), 1'b0);
	endtask

	// well-formed image, optionally cut short by an end of stream
	task automatic send_image(logic [31:0] img, int nb, bit cut);
		int unsigned left_px, cnt, top_cnt, pkt, cut_pkt;
		bit run;
		// huge images are never finished, only started and cut
		if (img > 32'd600) begin
			left_px = 600;
			cut = 1'b1;
		end else begin
			left_px = img;
		end
		cut_pkt = $urandom_range(0, 3);
		pkt = 0;
		while (left_px > 0) begin
			top_cnt = (left_px < 128) ? left_px : 128;
			case ($urandom_range(0, 4))
				0, 1: cnt = 1;
				2, 3: cnt = $urandom_range(1, (top_cnt < 8) ? top_cnt : 8);
				default: cnt = $urandom_range(1, top_cnt);
			endcase
			run = 1'($urandom_range(0, 1));
			send({run, 7'(cnt - 1)}, 1'b0);
			if (cut && pkt == cut_pkt) begin
				repeat ($urandom_range(0, nb - 1)) send(rand_byte(), 1'b0);
				send(rand_byte(), 1'b1);
				return;
			end
			if (run)
				send_pixel(nb);
			else
				repeat (cnt) send_pixel(nb);
			left_px -= cnt;
			pkt++;
		end
		if (cut)
			send(rand_byte(), 1'b1);
	endtask

	// header too long for images under 128 pixels, then random bytes and end of stream
	task automatic send_overrun(logic [31:0] img);
		int unsigned cnt;
		if (img < 32'd128) begin
			cnt = $urandom_range(img + 1, 128);
			send({1'($urandom_range(0, 1)), 7'(cnt - 1)}, 1'b0);
		end
		repeat ($urandom_range(0, 6)) send(rand_byte(), 1'b0);
		send(rand_byte(), 1'b1);
	endtask

	// random bytes and end markers, closed by an end of stream to resync
	task automatic send_noise();
		repeat ($urandom_range(1, 12))
			send(rand_byte(), $urandom_range(0, 5) == 0);
		send(rand_byte(), 1'b1);
	endtask

	task automatic directed();
		// end of stream between images
		send(8'h00, 1'b1);
		// one-pixel run completes the reset-size image
		send(8'h80, 1'b0);
		send(8'hff, 1'b0);
		configure(3'd4, 32'd200);
		// longest run, four-byte pixel
		send(8'hff, 1'b0);
		send(8'h00, 1'b0);
		send(8'hff, 1'b0);
		send(8'h5a, 1'b0);
		send(8'ha5, 1'b0);
		// overrun, ignored byte, end of stream
		send(8'h7f, 1'b0);
		send(8'h3c, 1'b0);
		send(8'hc3, 1'b1);
		// early end at a header after a finished pixel
		send(8'h80, 1'b0);
		send(8'h01, 1'b0);
		send(8'h02, 1'b0);
		send(8'h03, 1'b0);
		send(8'h04, 1'b0);
		send(8'h00, 1'b1);
		// early end inside an open raw packet
		send(8'h05, 1'b0);
		send(8'hff, 1'b1);
		// zero image size with a zero pixel size
		configure(3'd0, 32'd0);
		send(8'h00, 1'b0);
		send(8'h00, 1'b1);
		// both registers changed mid-pixel, image size dropping below the run
		configure(3'd2, 32'd10);
		send(8'h84, 1'b0);
		send(8'h11, 1'b0);
		settle();
		write_reg(CFG_IMAGE_PIXELS, 32'd2);
		write_reg(CFG_BYTES_PER_PIXEL, 32'd1);
		send(8'h22, 1'b0);
		// oversized pixel size acts as four bytes
		configure(3'd7, 32'd2);
		send(8'h80, 1'b0);
		send_pixel(4);
		send(8'h00, 1'b1);
	endtask

	task automatic random_phase();
		logic [2:0]  bpp;
		logic [31:0] img;
		int          nb, r;
		if ($urandom_range(0, 9) == 0)
			bpp = 3'($urandom_range(0, 7));
		else
			bpp = 3'($urandom_range(1, 4));
		r = $urandom_range(0, 99);
		if (r < 5)       img = 32'd0;
		else if (r < 8)  img = 32'hffff_ffff;
		else if (r < 11) img = 32'd4294836225;
		else if (r < 14) img = $urandom;
		else if (r < 22) img = 32'd1;
		else if (r < 30) img = $urandom_range(100, 400);
		else             img = $urandom_range(2, 40);
		configure(bpp, img);
		calm = ($urandom_range(0, 4) == 0);
		nb = eff_bytes(bpp);
		repeat ($urandom_range(1, 4)) begin
			if (sent >= ITEM_TARGET) break;
			r = $urandom_range(0, 99);
			if (img == 32'd0) begin
				if (r < 50) send_overrun(img);
				else send_noise();
			end else if (r < 65) begin
				send_image(img, nb, 1'b0);
				if ($urandom_range(0, 9) < 3)
					send(rand_byte(), 1'b1);
			end else if (r < 80) begin
				send_image(img, nb, 1'b1);
			end else if (r < 92) begin
				send_overrun(img);
			end else begin
				send_noise();
			end
		end
	endtask

	// result side: pop with random stalls
	initial begin : result_drain
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				pop <= 1'b0;
				hold--;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					hold = pick_gap();
			end
		end
	end

	// run limit
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// reset, stimulus and verdict
	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		directed();
		while (sent < ITEM_TARGET)
			random_phase();
		settle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
